### hdl/huffman_table_encoder_packer_unit_assert.svh
// Assertion macros shared by the packer RTL.
`ifndef HUFFMAN_TABLE_ENCODER_PACKER_UNIT_ASSERT_SVH
`define HUFFMAN_TABLE_ENCODER_PACKER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HTEP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("htep assertion failed");
`define HTEP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("htep implication failed");
`else
`define HTEP_ASSERT(lbl, prop)
`define HTEP_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

### hdl/htep_pkg.sv
package htep_pkg;

    localparam int WORD_BITS        = 24;
    localparam int BYTE_BITS        = 8;
    localparam int TOP_BIT          = 7;
    localparam int SYM_BITS         = 8;
    localparam int LEN_IN_BITS      = 5;
    localparam int TABLE_DEPTH      = 256;
    localparam int MAX_CODE_LEN_DEF = 24;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_ENCODE = 2'd1,
        CMD_FLUSH  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SHIFT,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic start;
        logic flush;
    } pk_ctrl_t;

    typedef struct packed {
        logic busy;
        logic flush_done;
    } pk_stat_t;

endpackage

### hdl/huffman_table_encoder_packer_unit.sv
// Channel | Dir | Signals                    | Contents
// s_      | in  | s_tvalid/s_tready/s_tdata  | symbol, code_word, code_length; tuser = cmd
// m_      | out | m_tvalid/m_tready/m_tdata  | out_byte; tlast = last_of_run
//
// Load writes the table while idle. Encode does a registered table read, then moves
// one code bit per cycle, unless stalled, through the bit packer's shift register.
// Stalls on m_ hold the packer when a full byte or a flush meets an occupied output register.
// Reset (aresetn low, synchronous) clears all table valid bits at once; no sweep.
`include "huffman_table_encoder_packer_unit_assert.svh"

module huffman_table_encoder_packer_unit #(
    parameter int MAX_CODE_LEN = htep_pkg::MAX_CODE_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [7:0] symbol, [31:8] code_word, [36:32] code_length
    input  logic [1:0]  s_tuser,  // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [7:0] out_byte
    output logic        m_tlast
);
    import htep_pkg::*;

    localparam int CODE_W = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int LEN_W  = $clog2(CODE_W + 1);

    state_t   state_reg, state_next;
    pk_ctrl_t ctrl;
    pk_stat_t stat;
    logic     tbl_wr;
    logic     tbl_rd;

    logic [CODE_W-1:0] rd_code;
    logic [LEN_W-1:0]  rd_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        tbl_wr     = 1'b0;
        tbl_rd     = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (cmd_t'(s_tuser))
                        CMD_LOAD:   tbl_wr = 1'b1;
                        CMD_ENCODE: begin
                            tbl_rd     = 1'b1;
                            state_next = ST_LOOKUP;
                        end
                        CMD_FLUSH:  state_next = ST_FLUSH;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOOKUP: begin
                ctrl.start = 1'b1;
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (!stat.busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                ctrl.flush = 1'b1;
                if (stat.flush_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    htep_code_table #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_table (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr_en      (tbl_wr),
        .rd_en      (tbl_rd),
        .addr       (s_tdata[7:0]),
        .code_word  (s_tdata[31:8]),
        .code_length(s_tdata[36:32]),
        .rd_code    (rd_code),
        .rd_len     (rd_len)
    );

    htep_bit_packer #(
        .MAX_CODE_LEN(MAX_CODE_LEN)
    ) u_packer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .code_in (rd_code),
        .len_in  (rd_len),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // tbl_rd is high exactly on an accepted encode transaction
    `HTEP_ASSERT(a_encode_to_lookup, tbl_rd |=> (state_reg == ST_LOOKUP))
    `HTEP_ASSERT(a_lookup_to_shift, (state_reg == ST_LOOKUP) |=> (state_reg == ST_SHIFT))
    `HTEP_ASSERT(a_shift_done_idle, (state_reg == ST_SHIFT && !stat.busy) |=> (state_reg == ST_IDLE))

endmodule

### hdl/htep_code_table.sv
module htep_code_table #(
    parameter int MAX_CODE_LEN = htep_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 wr_en,
    input  logic                                 rd_en,
    input  logic [htep_pkg::SYM_BITS-1:0]        addr,
    input  logic [htep_pkg::WORD_BITS-1:0]       code_word,
    input  logic [htep_pkg::LEN_IN_BITS-1:0]     code_length,
    output logic [((MAX_CODE_LEN < htep_pkg::WORD_BITS) ?
                   MAX_CODE_LEN : htep_pkg::WORD_BITS)-1:0] rd_code,
    output logic [$clog2(((MAX_CODE_LEN < htep_pkg::WORD_BITS) ?
                   MAX_CODE_LEN : htep_pkg::WORD_BITS) + 1)-1:0] rd_len
);
    import htep_pkg::*;

    localparam int CODE_W  = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int LEN_W   = $clog2(CODE_W + 1);
    localparam int ENTRY_W = CODE_W + LEN_W;

    logic [ENTRY_W-1:0]     mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [ENTRY_W-1:0]     rd_data_reg;
    logic                   rd_valid_reg;

    logic [LEN_W-1:0]  len_sat;
    logic [LEN_W-1:0]  shamt;
    logic [CODE_W-1:0] aligned;

    // Code is stored left-aligned so the packer takes the first bit from the MSB;
    // bits above the length fall off the top.
    always_comb begin
        if (32'(code_length) > CODE_W) begin
            len_sat = LEN_W'(CODE_W);
        end else begin
            len_sat = LEN_W'(code_length);
        end
        shamt   = LEN_W'(CODE_W) - len_sat;
        aligned = code_word[CODE_W-1:0] << shamt;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= {aligned, len_sat};
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    // never-loaded entry reads as empty code
    assign rd_code = rd_valid_reg ? rd_data_reg[ENTRY_W-1:LEN_W] : '0;
    assign rd_len  = rd_valid_reg ? rd_data_reg[LEN_W-1:0] : '0;

endmodule

### hdl/htep_bit_packer.sv
`include "huffman_table_encoder_packer_unit_assert.svh"

module htep_bit_packer #(
    parameter int MAX_CODE_LEN = htep_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  htep_pkg::pk_ctrl_t           ctrl,
    output htep_pkg::pk_stat_t           stat,
    input  logic [((MAX_CODE_LEN < htep_pkg::WORD_BITS) ?
                   MAX_CODE_LEN : htep_pkg::WORD_BITS)-1:0] code_in,
    input  logic [$clog2(((MAX_CODE_LEN < htep_pkg::WORD_BITS) ?
                   MAX_CODE_LEN : htep_pkg::WORD_BITS) + 1)-1:0] len_in,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [htep_pkg::BYTE_BITS-1:0] m_tdata,
    output logic                         m_tlast
);
    import htep_pkg::*;

    localparam int CODE_W = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int LEN_W  = $clog2(CODE_W + 1);

    logic [CODE_W-1:0]    code_reg, code_next;
    logic [LEN_W-1:0]     cnt_reg, cnt_next;
    logic [BYTE_BITS-1:0] part_reg, part_next;
    logic [2:0]           fill_reg, fill_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [BYTE_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    logic                 out_free;
    logic                 byte_full;
    logic                 step;
    logic                 do_flush;
    logic [BYTE_BITS-1:0] part_bit;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign byte_full = (fill_reg == 3'(TOP_BIT));
    assign step      = (cnt_reg != '0) && (!byte_full || out_free);
    assign do_flush  = ctrl.flush && (cnt_reg == '0) && out_free;

    always_comb begin
        part_bit = part_reg;
        part_bit[3'(TOP_BIT) - fill_reg] = code_reg[CODE_W-1];

        code_next     = code_reg;
        cnt_next      = cnt_reg;
        part_next     = part_reg;
        fill_next     = fill_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (ctrl.start) begin
            code_next = code_in;
            cnt_next  = len_in;
        end else if (step) begin
            code_next = code_reg << 1;
            cnt_next  = cnt_reg - 1'b1;
            if (byte_full) begin
                // last byte of this symbol when fewer than a byte of bits remain
                m_tvalid_next = 1'b1;
                m_tdata_next  = part_bit;
                m_tlast_next  = (32'(cnt_reg) <= 32'(BYTE_BITS));
                part_next     = '0;
                fill_next     = '0;
            end else begin
                part_next = part_bit;
                fill_next = fill_reg + 1'b1;
            end
        end else if (do_flush) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = part_reg;
            m_tlast_next  = 1'b1;
            part_next     = '0;
            fill_next     = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= '0;
            part_reg     <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            part_reg     <= part_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        code_reg    <= code_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign stat.busy       = (cnt_reg != '0);
    assign stat.flush_done = do_flush;
    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign m_tlast         = m_tlast_reg;

    `HTEP_ASSERT_IMPL(a_start_when_idle, ctrl.start, cnt_reg == '0)
    `HTEP_ASSERT(a_stall_holds, (cnt_reg != '0 && byte_full && !out_free) |=> $stable(cnt_reg))
    `HTEP_ASSERT(a_flush_clears, do_flush |=> (fill_reg == '0 && part_reg == '0 && m_tvalid_reg))

endmodule

### tb/huffman_table_encoder_packer_unit_test.sv
`timescale 1ns / 1ps

import htep_pkg::*;

localparam logic [1:0] CMD_UNUSED = 2'd3;
localparam int CODE_LEN_LIMIT =
    (MAX_CODE_LEN_DEF < WORD_BITS) ? MAX_CODE_LEN_DEF : WORD_BITS;
localparam int EXP_DEPTH = 256;

typedef struct packed {
    logic [23:0] code;
    logic [4:0]  len;
} code_entry_t;

typedef struct packed {
    logic [7:0] value;
    logic       is_last;
} packed_byte_t;

class huff_byte_scoreboard;
    code_entry_t  code_table [TABLE_DEPTH];
    logic [7:0]   partial;
    int           filled;
    packed_byte_t exp_fifo [EXP_DEPTH];
    int           exp_wr, exp_rd, pending;
    int           error_count;
    int           n_loads, n_encodes, n_flushes, n_ignored, n_bytes;

    function new();
        foreach (code_table[i]) code_table[i] = '0;
        partial     = '0;
        filled      = 0;
        exp_wr      = 0;
        exp_rd      = 0;
        pending     = 0;
        error_count = 0;
        n_loads     = 0;
        n_encodes   = 0;
        n_flushes   = 0;
        n_ignored   = 0;
        n_bytes     = 0;
    endfunction

    function void note_error(string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR: %s", msg);
    endfunction

    function void store_byte(packed_byte_t pb);
        exp_fifo[exp_wr] = pb;
        exp_wr = (exp_wr + 1) % EXP_DEPTH;
        pending++;
    endfunction

    function packed_byte_t take_byte();
        packed_byte_t pb;
        pb = exp_fifo[exp_rd];
        exp_rd = (exp_rd + 1) % EXP_DEPTH;
        pending--;
        return pb;
    endfunction

    // Called once per accepted input transaction; queues the bytes it should produce.
    function void note_item(logic [1:0] cmd, logic [7:0] sym, logic [23:0] word,
                            logic [4:0] len_in);
        int           len_v;
        int           i;
        int           n;
        logic [31:0]  mask;
        logic [23:0]  code_v;
        packed_byte_t pb;
        n = 0;
        case (cmd)
            CMD_LOAD: begin
                n_loads++;
                len_v = len_in;
                if (len_v > CODE_LEN_LIMIT) len_v = CODE_LEN_LIMIT;
                mask = (32'd1 << len_v) - 32'd1;
                code_table[sym].code = word & mask[23:0];
                code_table[sym].len  = 5'(len_v);
            end
            CMD_ENCODE: begin
                n_encodes++;
                code_v = code_table[sym].code;
                for (i = code_table[sym].len; i > 0; i--) begin
                    partial[TOP_BIT - filled] = code_v[i - 1];
                    filled++;
                    if (filled == BYTE_BITS) begin
                        pb.value   = partial;
                        pb.is_last = 1'b0;
                        store_byte(pb);
                        n++;
                        partial = '0;
                        filled  = 0;
                    end
                end
                if (n > 0) exp_fifo[(exp_wr + EXP_DEPTH - 1) % EXP_DEPTH].is_last = 1'b1;
            end
            CMD_FLUSH: begin
                n_flushes++;
                pb.value   = partial;
                pb.is_last = 1'b1;
                store_byte(pb);
                partial = '0;
                filled  = 0;
            end
            default: n_ignored++;
        endcase
    endfunction

    function void check_byte(logic [7:0] value, logic is_last);
        packed_byte_t exp_b;
        n_bytes++;
        if (pending == 0) begin
            note_error($sformatf("unexpected byte %02h last=%0b", value, is_last));
        end else begin
            exp_b = take_byte();
            if (exp_b.value !== value)
                note_error($sformatf("byte %0d: out_byte expected %02h got %02h",
                                     n_bytes, exp_b.value, value));
            else if (exp_b.is_last !== is_last)
                note_error($sformatf("byte %0d: last_of_run expected %0b got %0b",
                                     n_bytes, exp_b.is_last, is_last));
        end
    endfunction

    function void check_drained();
        if (pending != 0)
            note_error($sformatf("%0d expected bytes never arrived", pending));
    endfunction
endclass

module huffman_table_encoder_packer_unit_test;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 255;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    huff_byte_scoreboard sb = new();
    int   cycle_count   = 0;
    bit   pressure_go   = 1'b0;
    bit   pressure_done = 1'b0;
    int   loaded_syms [TABLE_DEPTH];
    int   n_loaded      = 0;

    huffman_table_encoder_packer_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_byte(m_tdata, m_tlast);
    end

    // Receiver: stall pattern changes after each random-length run, plus one long hold-off.
    initial begin
        int mode;
        int run_left;
        int hold_cnt;
        bit toggle;
        mode     = 0;
        run_left = 0;
        toggle   = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (pressure_go && !pressure_done) begin
                m_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(negedge aclk);
                    hold_cnt++;
                end
                pressure_done = 1'b1;
                m_tready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    mode     = $urandom_range(0, 3);
                    run_left = $urandom_range(16, 96);
                end
                run_left--;
                toggle = !toggle;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 9) < 7);
                    2:       m_tready <= ($urandom_range(0, 9) < 3);
                    default: m_tready <= toggle;
                endcase
            end
        end
    end

    // Holds tvalid high across back-to-back items; only idle_cycles lowers it.
    task automatic send_item(logic [1:0] cmd, logic [7:0] sym, logic [23:0] word,
                             logic [4:0] len);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, len, word, sym};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_item(cmd, sym, word, len);
        if (cmd == CMD_LOAD && len != 0 && n_loaded < TABLE_DEPTH) begin
            loaded_syms[n_loaded] = sym;
            n_loaded++;
        end
    endtask

    task automatic idle_cycles(int n);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (n - 1) @(negedge aclk);
    endtask

    task automatic send_random_item();
        int          pick;
        int          len_v;
        logic [7:0]  sym;
        pick = $urandom_range(0, 99);
        sym  = 8'($urandom_range(0, 255));
        if (pick < 15 || n_loaded == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      len_v = $urandom_range(1, 8);
            else if (pick < 90) len_v = $urandom_range(9, 24);
            else if (pick < 95) len_v = 0;
            else                len_v = $urandom_range(25, 31);
            send_item(CMD_LOAD, sym, 24'($urandom()), 5'(len_v));
        end else if (pick < 85) begin
            if ($urandom_range(0, 4) != 0)
                sym = 8'(loaded_syms[$urandom_range(0, n_loaded - 1)]);
            send_item(CMD_ENCODE, sym, 24'($urandom()), 5'($urandom()));
        end else if (pick < 95) begin
            send_item(CMD_FLUSH, sym, 24'($urandom()), 5'($urandom()));
        end else begin
            send_item(CMD_UNUSED, sym, 24'($urandom()), 5'($urandom()));
        end
    endtask

    initial begin
        int sent;
        int burst;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty codes, saturation, masking, length 31, empty flush
        send_item(CMD_ENCODE, 8'd0,   24'h000000, 5'd0);
        send_item(CMD_FLUSH,  8'd0,   24'h000000, 5'd0);
        send_item(CMD_LOAD,   8'd3,   24'h00007F, 5'd7);
        send_item(CMD_ENCODE, 8'd3,   24'h000000, 5'd0);
        send_item(CMD_LOAD,   8'd255, 24'hFFFFFF, 5'd31);
        send_item(CMD_ENCODE, 8'd255, 24'h000000, 5'd0);
        send_item(CMD_FLUSH,  8'd255, 24'hFFFFFF, 5'd31);
        send_item(CMD_LOAD,   8'd1,   24'hFFFFFE, 5'd1);
        send_item(CMD_LOAD,   8'd2,   24'hA5A5A5, 5'd24);
        send_item(CMD_ENCODE, 8'd2,   24'h000000, 5'd0);
        send_item(CMD_ENCODE, 8'd1,   24'h000000, 5'd0);
        send_item(CMD_LOAD,   8'd0,   24'h123456, 5'd0);
        send_item(CMD_ENCODE, 8'd0,   24'h000000, 5'd0);
        send_item(CMD_UNUSED, 8'd2,   24'hFFFFFF, 5'd31);
        send_item(CMD_LOAD,   8'd128, 24'hFFFF5A, 5'd8);
        send_item(CMD_ENCODE, 8'd128, 24'h000000, 5'd0);
        send_item(CMD_LOAD,   8'd4,   24'h00C3A5, 5'd16);
        send_item(CMD_ENCODE, 8'd4,   24'h000000, 5'd0);
        send_item(CMD_ENCODE, 8'd3,   24'h000000, 5'd0);
        send_item(CMD_FLUSH,  8'd0,   24'h000000, 5'd0);
        send_item(CMD_LOAD,   8'd5,   24'h800001, 5'd25);
        send_item(CMD_ENCODE, 8'd5,   24'h000000, 5'd0);
        send_item(CMD_FLUSH,  8'd0,   24'h000000, 5'd0);
        send_item(CMD_ENCODE, 8'd255, 24'h000000, 5'd0);
        send_item(CMD_FLUSH,  8'd0,   24'h000000, 5'd0);
        idle_cycles(3);

        pressure_go = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                send_random_item();
                sent++;
            end
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
        end
        idle_cycles(1);

        while (sb.pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.check_drained();

        $display("covered %0d loads, %0d encodes, %0d flushes, %0d unused commands",
                 sb.n_loads, sb.n_encodes, sb.n_flushes, sb.n_ignored);
        $display("%0d output bytes checked, %0d mismatches", sb.n_bytes, sb.error_count);
        if (sb.error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/htep_pkg.sv
hdl/htep_code_table.sv
hdl/htep_bit_packer.sv
hdl/huffman_table_encoder_packer_unit.sv
tb/huffman_table_encoder_packer_unit_test.sv
